// ===== sv/srfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor response frame decoder package
// Shared types, codes and sizes of the frame decoder.
// ----------------------------------------------------------------------------
package srfd_pkg;

    localparam int MAX_READ_BYTES   = 1024;
    localparam int WORD_STORE_DEPTH = 16;
    localparam int STORE_AW         = $clog2(WORD_STORE_DEPTH);
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
    localparam int NUM_CHANNELS     = 4;

    localparam logic [10:0] MAX_READ_COUNT = 11'(MAX_READ_BYTES);
    localparam logic [4:0]  STORE_DEPTH_LEN = 5'(WORD_STORE_DEPTH);

    localparam logic [7:0] DELIM_BYTE = 8'h7E;
    localparam logic [7:0] ERR_MSB    = 8'h7D;
    localparam logic [7:0] ERR_LSB    = 8'h31;
    localparam logic [7:0] NOS_MSB    = 8'h7F;
    localparam logic [7:0] NOS_LSB    = 8'hFF;
    localparam logic [4:0] MIN_WORD   = 5'd11;
    localparam logic [4:0] MAX_WORD   = 5'd15;

    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_NOSENSOR = 2'd1;
    localparam logic [1:0] ST_CHERR    = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         channel;
        logic [1:0]         status;
        logic signed [15:0] value;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic                wr;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
        logic                dec;
        logic [4:0]          len;
        logic                ovf;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

endpackage

// ===== sv/srfd_front.sv =====
// ----------------------------------------------------------------------------
// Frame decoder front end
// Tracks the query and delimiters and turns received bytes into store
// writes and decode commands.
// ----------------------------------------------------------------------------
module srfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  srfd_pkg::t_in_item i_item,
    output srfd_pkg::t_push   o_push
);
    import srfd_pkg::*;

    logic        r_in_frame, n_in_frame;
    logic        r_query_done, n_query_done;
    logic [10:0] r_bytes_read, n_bytes_read;
    logic [4:0]  r_word_length, n_word_length;
    logic        r_word_overflow, n_word_overflow;
    logic        wr, fin;

    always_comb begin
        n_in_frame      = r_in_frame;
        n_query_done    = r_query_done;
        n_bytes_read    = r_bytes_read;
        n_word_length   = r_word_length;
        n_word_overflow = r_word_overflow;
        wr              = 1'b0;
        fin             = 1'b0;
        if (i_accept) begin
            if (i_item.operation == OP_START) begin
                n_in_frame      = 1'b0;
                n_query_done    = 1'b0;
                n_bytes_read    = '0;
                n_word_length   = '0;
                n_word_overflow = 1'b0;
            end else if (!r_query_done) begin
                n_bytes_read = r_bytes_read + 11'd1;
                if (i_item.rx_byte == DELIM_BYTE) begin
                    if (!r_in_frame) begin
                        n_in_frame = 1'b1;
                    end else begin
                        fin = 1'b1;
                    end
                end else if (r_in_frame) begin
                    if (r_word_length < STORE_DEPTH_LEN) begin
                        wr            = 1'b1;
                        n_word_length = r_word_length + 5'd1;
                    end else begin
                        n_word_overflow = 1'b1;
                    end
                end
                if (n_bytes_read >= MAX_READ_COUNT) begin
                    fin = 1'b1;
                end
                if (fin) begin
                    n_query_done = 1'b1;
                    n_in_frame   = 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_push.push     = wr | fin;
        o_push.cmd.wr   = wr;
        o_push.cmd.addr = r_word_length[STORE_AW-1:0];
        o_push.cmd.data = i_item.rx_byte;
        o_push.cmd.dec  = fin;
        o_push.cmd.len  = n_word_length;
        o_push.cmd.ovf  = n_word_overflow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame      <= 1'b0;
            r_query_done    <= 1'b1;
            r_bytes_read    <= '0;
            r_word_length   <= '0;
            r_word_overflow <= 1'b0;
        end else begin
            r_in_frame      <= n_in_frame;
            r_query_done    <= n_query_done;
            r_bytes_read    <= n_bytes_read;
            r_word_length   <= n_word_length;
            r_word_overflow <= n_word_overflow;
        end
    end

endmodule

// ===== sv/srfd_queue.sv =====
// ----------------------------------------------------------------------------
// Frame decoder command queue
// Short first-in first-out queue between the front end and the decoder.
// ----------------------------------------------------------------------------
module srfd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  srfd_pkg::t_push i_push,
    input  logic            i_pop,
    output srfd_pkg::t_cmd  o_head,
    output logic            o_full,
    output logic            o_empty
);
    import srfd_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [QUEUE_AW:0]   r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

// ===== sv/srfd_back.sv =====
// ----------------------------------------------------------------------------
// Frame decoder back end
// Holds the word store, decodes a finished word into four channel results
// and presents them through the output register.
// ----------------------------------------------------------------------------
module srfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srfd_pkg::t_cmd      i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    output srfd_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import srfd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_mem [WORD_STORE_DEPTH];
    logic [7:0]  r_rd_msb, r_rd_lsb;
    logic [4:0]  r_len, n_len;
    logic [4:0]  r_pos, n_pos;
    logic [1:0]  r_ch, n_ch;
    logic        r_bad, n_bad;
    logic [1:0]  r_st [NUM_CHANNELS];
    logic [15:0] r_val [NUM_CHANNELS];
    logic        r_out_valid;
    t_out_item   r_out_data;
    logic        out_free, load_out, eval_en;
    logic [4:0]  addr_a, addr_b, trim;
    logic        is_err, is_nos;
    logic [1:0]  eval_st;
    logic [15:0] eval_val;
    t_out_item   emit_item;

    assign out_free = !r_out_valid || !i_out_stall;
    assign addr_a   = r_pos + 5'd2;
    assign addr_b   = r_pos + 5'd3;
    assign trim     = r_len - 5'd3;
    assign is_err   = (r_rd_msb == ERR_MSB) && (r_rd_lsb == ERR_LSB);
    assign is_nos   = (r_rd_msb == NOS_MSB) && (r_rd_lsb == NOS_LSB);

    always_comb begin
        priority if (is_err) begin
            eval_st  = ST_CHERR;
            eval_val = '0;
        end else if (is_nos) begin
            eval_st  = ST_NOSENSOR;
            eval_val = '0;
        end else begin
            eval_st  = ST_VALID;
            eval_val = {r_rd_msb, r_rd_lsb};
        end
    end

    always_comb begin
        emit_item.channel = r_ch;
        emit_item.status  = r_bad ? ST_INVALID : r_st[r_ch];
        emit_item.value   = r_bad ? 16'sd0 : $signed(r_val[r_ch]);
        emit_item.last    = (r_ch == 2'd3);
    end

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_pos    = r_pos;
        n_ch     = r_ch;
        n_bad    = r_bad;
        o_pop    = 1'b0;
        load_out = 1'b0;
        eval_en  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_head.dec) begin
                        n_len = i_head.len;
                        n_pos = '0;
                        n_ch  = '0;
                        n_bad = i_head.ovf || (i_head.len < MIN_WORD)
                                || (i_head.len > MAX_WORD);
                        n_state = n_bad ? S_EMIT : S_READ;
                    end
                end
            end
            S_READ: begin
                if ((r_pos + 5'd1) >= trim) begin
                    n_bad   = 1'b1;
                    n_ch    = '0;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                eval_en = 1'b1;
                n_pos   = r_pos + (is_err ? 5'd3 : 5'd2);
                n_ch    = r_ch + 2'd1;
                n_state = (r_ch == 2'd3) ? S_EMIT : S_READ;
            end
            S_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_ch     = r_ch + 2'd1;
                    if (r_ch == 2'd3) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.wr) begin
            r_mem[i_head.addr] <= i_head.data;
        end
        r_rd_msb <= r_mem[addr_a[STORE_AW-1:0]];
        r_rd_lsb <= r_mem[addr_b[STORE_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (eval_en) begin
            r_st[r_ch]  <= eval_st;
            r_val[r_ch] <= eval_val;
        end
        if (load_out) begin
            r_out_data <= emit_item;
        end
        r_len <= n_len;
        r_pos <= n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_bad   <= n_bad;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== sv/sensor_response_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Sensor response frame decoder
// Decodes a delimited sensor response word into four channel results.
// ----------------------------------------------------------------------------
// Input channel: one transfer is a start event or one received byte. A start
// opens a new query; bytes between the first and second 0x7E delimiter form
// the data word, and the query closes on the second delimiter or when the
// byte count reaches the read limit.
// Output channel: each closed query yields four transfers, channels 0 to 3,
// with last set on channel 3.
// Each accepted input transfer yields at most one push from the front end. A
// closed query is decoded by the back end in a read and an evaluate state per
// channel through the two-port word store read. The first result is registered
// once all four channels are evaluated, and the results then follow one per
// cycle while the receiver does not stall. A word of bad length skips the reads.
// Up to four store writes and decode commands wait in the queue; o_in_stall
// rises only when it is full, for instance while results are held back.
// When the receiver stalls, the result register holds its transfer unchanged.
// After reset no query is open and received bytes are dropped until a start.
// ----------------------------------------------------------------------------
module sensor_response_frame_decoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  srfd_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output srfd_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import srfd_pkg::*;

    t_push q_push;
    t_cmd  q_head;
    logic  q_full, q_empty, q_pop, in_accept;

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    srfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .o_push   (q_push)
    );

    srfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    srfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push.push |-> !q_full)
        else $error("command pushed into a full queue");

    a_last_ch3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last) |-> (o_out_data.channel == 2'd3))
        else $error("last flag on a channel other than 3");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_VALID)) |-> (o_out_data.value == 16'sd0))
        else $error("nonzero value on a result without a valid reading");
`endif

endmodule
